### rtl/selection_outline_edge_update_macros.svh
// Assertion helpers, clocked on clk, quiet while rst_n is low.
`ifndef SELECTION_OUTLINE_EDGE_UPDATE_MACROS_SVH
`define SELECTION_OUTLINE_EDGE_UPDATE_MACROS_SVH

// same-cycle implication
`define SOEU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SOEU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/soeu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package soeu_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic signed [1:0] EV_POS  = 2'sb01;
    localparam logic signed [1:0] EV_NEG  = 2'sb11;
    localparam logic signed [1:0] EV_ZERO = 2'sb00;

    typedef struct packed {
        logic [8:0]  gw;
        logic [8:0]  gh;
        logic [9:0]  cols;
        logic [9:0]  rows;
        logic [19:0] area;
    } grid_cfg_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    function automatic logic [8:0] clamp_size(input logic [8:0] v, input int maxv);
        if (v == 9'd0) begin
            return 9'd1;
        end
        if (int'(v) > maxv) begin
            return 9'(maxv);
        end
        return v;
    endfunction

    // pos_side: left and bottom edges carry the positive orientation
    function automatic logic signed [1:0] edge_val(input logic removing, input logic nb,
                                                   input logic pos_side);
        if (!removing) begin
            if (nb) begin
                return EV_ZERO;
            end
            return pos_side ? EV_POS : EV_NEG;
        end
        if (nb) begin
            return pos_side ? EV_NEG : EV_POS;
        end
        return EV_ZERO;
    endfunction

endpackage

`default_nettype wire

### rtl/soeu_map_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module soeu_map_mem
    import soeu_pkg::*;
#(
    parameter int WIDTH = 256,
    parameter int DEPTH = 256
)
(
    input  wire logic                     clk,
    input  wire mem_ctl_t                 ctl,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] map_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            map_mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rd_data_reg <= map_mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/soeu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "selection_outline_edge_update_macros.svh"

module soeu_ctrl
    import soeu_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire grid_cfg_t                     cfg,
    input  wire logic                          clear_req,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          func,
    input  wire logic [7:0]                    pixel_x,
    input  wire logic [7:0]                    pixel_y,
    output mem_ctl_t                           mem_ctl,
    output logic      [$clog2(MAX_HEIGHT)-1:0] waddr,
    output logic      [MAX_WIDTH-1:0]          wdata,
    output logic      [$clog2(MAX_HEIGHT)-1:0] raddr,
    input  wire logic [MAX_WIDTH-1:0]          rd_data,
    output logic                               edge_strobe,
    output logic      [17:0]                   edge_index,
    output logic signed [1:0]                  edge_value,
    output logic                               last_edge
);

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_RGT  = 3'd3;
    localparam logic [2:0] ST_TOP  = 3'd4;
    localparam logic [2:0] ST_BOT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [RW-1:0] clr_cnt_reg;

    logic        rem_reg;
    logic [7:0]  x_reg, y_reg;
    logic [17:0] xr_reg, yc_reg;
    logic [19:0] vb_reg, hb_reg;
    logic        r_reg, t_reg, b_reg;
    logic        top_ok_reg, bot_ok_reg;

    logic        strobe_reg;
    logic [17:0] idx_reg;
    logic signed [1:0] val_reg;
    logic        last_reg;

    logic        accept;
    logic        in_grid;
    logic        chg;
    logic        emit;
    logic        emit_last;
    logic signed [1:0] emit_val;
    logic [19:0] idx_sum;
    logic [19:0] vb;
    logic [19:0] hb;
    logic [CW-1:0] x_col;
    logic [PW-1:0] px;
    logic [MAX_WIDTH+1:0] padded;
    logic [MAX_WIDTH-1:0] row_mod;
    logic        self_bit, l_bit, r_bit;

    assign busy    = !(state_reg == ST_IDLE || state_reg == ST_BOT);
    assign accept  = start && !busy;
    assign in_grid = ({1'b0, pixel_x} < cfg.gw) && ({1'b0, pixel_y} < cfg.gh);

    assign x_col    = CW'(x_reg);
    assign px       = PW'(x_reg);
    assign padded   = {1'b0, rd_data, 1'b0};
    assign self_bit = rd_data[x_col];
    assign l_bit    = padded[px];
    assign r_bit    = padded[px + PW'(2)];
    assign chg      = (self_bit == rem_reg);

    assign vb = cfg.area + 20'(xr_reg) + 20'(y_reg);
    assign hb = 20'(yc_reg) + 20'(x_reg);

    always_comb
    begin
        row_mod        = rd_data;
        row_mod[x_col] = !rem_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        mem_ctl.we  = 1'b0;
        mem_ctl.re  = 1'b0;
        waddr       = RW'(y_reg);
        wdata       = row_mod;
        raddr       = RW'(y_reg);
        emit        = 1'b0;
        emit_last   = 1'b0;
        emit_val    = EV_ZERO;
        idx_sum     = '0;
        unique case (state_reg)
            ST_CLR:
            begin
                mem_ctl.we = 1'b1;
                waddr      = clr_cnt_reg;
                wdata      = '0;
                if (clr_cnt_reg == RW'(MAX_HEIGHT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_CHK:
            begin
                if (chg)
                begin
                    mem_ctl.we = 1'b1;
                    mem_ctl.re = top_ok_reg;
                    raddr      = RW'(y_reg - 8'd1);
                    emit       = 1'b1;
                    idx_sum    = vb;
                    emit_val   = edge_val(rem_reg, l_bit, 1'b1);
                    state_next = ST_RGT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RGT:
            begin
                mem_ctl.re = bot_ok_reg;
                raddr      = RW'({1'b0, y_reg} + 9'd1);
                emit       = 1'b1;
                idx_sum    = vb_reg + 20'(cfg.rows);
                emit_val   = edge_val(rem_reg, r_reg, 1'b0);
                state_next = ST_TOP;
            end
            ST_TOP:
            begin
                emit       = 1'b1;
                idx_sum    = hb;
                emit_val   = edge_val(rem_reg, t_reg, 1'b0);
                state_next = ST_BOT;
            end
            ST_BOT:
            begin
                emit       = 1'b1;
                emit_last  = 1'b1;
                idx_sum    = hb_reg + 20'(cfg.cols);
                emit_val   = edge_val(rem_reg, b_reg, 1'b1);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
        if (accept)
        begin
            mem_ctl.re = 1'b1;
            raddr      = RW'(pixel_y);
            state_next = in_grid ? ST_CHK : ST_IDLE;
        end
        if (clear_req)
        begin
            state_next = ST_CLR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit;
            if (clear_req)
            begin
                clr_cnt_reg <= '0;
            end
            else if (state_reg == ST_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_sum[17:0];
        val_reg  <= emit_val;
        last_reg <= emit_last;
        if (accept)
        begin
            rem_reg    <= (func == FUNC_REMOVE);
            x_reg      <= pixel_x;
            y_reg      <= pixel_y;
            xr_reg     <= 18'(pixel_x) * 18'(cfg.rows);
            yc_reg     <= 18'(pixel_y) * 18'(cfg.cols);
            top_ok_reg <= (pixel_y != 8'd0);
            bot_ok_reg <= (({1'b0, pixel_y} + 9'd1) < cfg.gh);
        end
        if (state_reg == ST_CHK)
        begin
            r_reg  <= r_bit;
            vb_reg <= vb;
        end
        if (state_reg == ST_RGT)
        begin
            t_reg <= top_ok_reg && rd_data[x_col];
        end
        if (state_reg == ST_TOP)
        begin
            b_reg  <= bot_ok_reg && rd_data[x_col];
            hb_reg <= hb;
        end
    end

    assign edge_strobe = strobe_reg;
    assign edge_index  = idx_reg;
    assign edge_value  = val_reg;
    assign last_edge   = last_reg;

    `SOEU_ASSERT_NEXT(a_burst_cont, strobe_reg && !last_reg, strobe_reg, "edge burst broken")
    `SOEU_ASSERT_NOW(a_burst_four, strobe_reg && last_reg, $past(strobe_reg, 3), "short burst")
    `SOEU_ASSERT_NOW(a_clr_no_read, state_reg == ST_CLR, !mem_ctl.re, "row read during clear")

endmodule

`default_nettype wire

### rtl/selection_outline_edge_update.sv
`timescale 1ns / 1ps
`default_nettype none
// CHK registers the first edge update from the row read at start; then one per cycle.
// Start is taken again in ST_BOT; three row reads share the map's single read port.
// Out-of-grid items return to idle at once, no-change items after CHK, with no updates.
// Reset and any grid size write clear the map, one row per cycle, while busy.
// The receiver cannot stall; each update is on the ports for one cycle only.

module selection_outline_edge_update
    import soeu_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 func,
    input  wire logic [7:0]           pixel_x,
    input  wire logic [7:0]           pixel_y,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [8:0]           cfg_data,
    output logic                      edge_strobe,
    output logic      [17:0]          edge_index,
    output logic signed [1:0]         edge_value,
    output logic                      last_edge
);

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [8:0] GW_RST = 9'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
    localparam logic [8:0] GH_RST = 9'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

    logic [8:0]  gw_reg, gh_reg;
    logic [19:0] area_reg;
    logic        cfg_xfer;
    logic        clear_req;
    grid_cfg_t   cfg;
    mem_ctl_t    mem_ctl;
    logic [RW-1:0]        waddr, raddr;
    logic [MAX_WIDTH-1:0] wdata, rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign clear_req = cfg_xfer &&
                       (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= GW_RST;
            gh_reg <= GH_RST;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  gw_reg <= clamp_size(cfg_data, MAX_WIDTH);
                REG_GRID_HEIGHT: gh_reg <= clamp_size(cfg_data, MAX_HEIGHT);
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.gw   = gw_reg;
    assign cfg.gh   = gh_reg;
    assign cfg.cols = {1'b0, gw_reg} + 10'd1;
    assign cfg.rows = {1'b0, gh_reg} + 10'd1;
    assign cfg.area = area_reg;

    always_ff @(posedge clk)
    begin
        area_reg <= 20'(cfg.cols) * 20'(cfg.rows);
    end

    soeu_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .clear_req   (clear_req),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .mem_ctl     (mem_ctl),
        .waddr       (waddr),
        .wdata       (wdata),
        .raddr       (raddr),
        .rd_data     (rd_data),
        .edge_strobe (edge_strobe),
        .edge_index  (edge_index),
        .edge_value  (edge_value),
        .last_edge   (last_edge)
    );

    soeu_map_mem #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_map (
        .clk     (clk),
        .ctl     (mem_ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

### verif/selection_outline_edge_update_checker.sv
`timescale 1ns / 1ps

module selection_outline_edge_update_checker
    import soeu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 func,
    input  wire logic [7:0]           pixel_x,
    input  wire logic [7:0]           pixel_y,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [8:0]           cfg_data,
    input  wire logic                 edge_strobe,
    input  wire logic [17:0]          edge_index,
    input  wire logic signed [1:0]    edge_value,
    input  wire logic                 last_edge,
    output int                        errors,
    output int                        outstanding
);

    localparam int GRID_MAX = 256;

    typedef struct packed {
        logic [17:0]       idx;
        logic signed [1:0] val;
        logic              last;
    } edge_upd_t;

    bit [GRID_MAX*GRID_MAX-1:0] sel_map;
    int                         grid_w;
    int                         grid_h;
    edge_upd_t                  edge_q[$];
    int                         err_count;
    int                         pend_cnt;

    assign errors      = err_count;
    assign outstanding = pend_cnt;

    function automatic bit pixel_on(input int x, input int y);
        if (x < 0 || y < 0 || x >= grid_w || y >= grid_h)
        begin
            return 1'b0;
        end
        return sel_map[y * GRID_MAX + x];
    endfunction

    function automatic logic [17:0] h_edge(input int x, input int y);
        return 18'(y * (grid_w + 1) + x);
    endfunction

    function automatic logic [17:0] v_edge(input int x, input int y);
        return 18'((grid_h + 1) * (grid_w + 1) + x * (grid_h + 1) + y);
    endfunction

    function automatic int size_from_reg(input logic [8:0] v);
        if (v == 9'd0)
        begin
            return 1;
        end
        if (int'(v) > GRID_MAX)
        begin
            return GRID_MAX;
        end
        return int'(v);
    endfunction

    task automatic push_edge(input logic [17:0] idx, input logic signed [1:0] val,
                             input logic last);
        edge_upd_t u;
        u.idx  = idx;
        u.val  = val;
        u.last = last;
        edge_q.push_back(u);
    endtask

    // order: left, right, top, bottom
    task automatic predict_request(input logic fn, input logic [7:0] px, input logic [7:0] py);
        int x;
        int y;
        bit removing;
        bit l;
        bit r;
        bit t;
        bit b;
        x        = int'(px);
        y        = int'(py);
        removing = (fn == FUNC_REMOVE);
        if (x >= grid_w || y >= grid_h)
        begin
            return;
        end
        if (pixel_on(x, y) != removing)
        begin
            return;
        end
        sel_map[y * GRID_MAX + x] = !removing;
        l = pixel_on(x - 1, y);
        r = pixel_on(x + 1, y);
        t = pixel_on(x, y - 1);
        b = pixel_on(x, y + 1);
        if (!removing)
        begin
            push_edge(v_edge(x, y),     l ? EV_ZERO : EV_POS, 1'b0);
            push_edge(v_edge(x + 1, y), r ? EV_ZERO : EV_NEG, 1'b0);
            push_edge(h_edge(x, y),     t ? EV_ZERO : EV_NEG, 1'b0);
            push_edge(h_edge(x, y + 1), b ? EV_ZERO : EV_POS, 1'b1);
        end
        else
        begin
            push_edge(v_edge(x, y),     l ? EV_NEG : EV_ZERO, 1'b0);
            push_edge(v_edge(x + 1, y), r ? EV_POS : EV_ZERO, 1'b0);
            push_edge(h_edge(x, y),     t ? EV_POS : EV_ZERO, 1'b0);
            push_edge(h_edge(x, y + 1), b ? EV_NEG : EV_ZERO, 1'b1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        edge_upd_t exp_u;
        if (!rst_n)
        begin
            grid_w    = GRID_MAX;
            grid_h    = GRID_MAX;
            sel_map   = '0;
            edge_q.delete();
            err_count = 0;
            pend_cnt  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:
                    begin
                        grid_w  = size_from_reg(cfg_data);
                        sel_map = '0;
                    end
                    REG_GRID_HEIGHT:
                    begin
                        grid_h  = size_from_reg(cfg_data);
                        sel_map = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (edge_strobe)
            begin
                if (edge_q.size() == 0)
                begin
                    if (err_count < 10)
                    begin
                        $display("%0t: unexpected edge update idx %0d val %0d last %0d",
                                 $realtime, edge_index, edge_value, last_edge);
                    end
                    err_count++;
                end
                else
                begin
                    exp_u = edge_q.pop_front();
                    if (edge_index !== exp_u.idx || edge_value !== exp_u.val ||
                        last_edge !== exp_u.last)
                    begin
                        if (err_count < 10)
                        begin
                            $display("%0t: edge mismatch exp idx %0d val %0d last %0d, got idx %0d val %0d last %0d",
                                     $realtime, exp_u.idx, exp_u.val, exp_u.last,
                                     edge_index, edge_value, last_edge);
                        end
                        err_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_request(func, pixel_x, pixel_y);
            end
            pend_cnt = edge_q.size();
        end
    end

endmodule

### verif/selection_outline_edge_update_tb.sv
`timescale 1ns / 1ps

module selection_outline_edge_update_tb;
    import soeu_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 45;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    logic                 func      = FUNC_ADD;
    logic [7:0]           pixel_x   = 8'd0;
    logic [7:0]           pixel_y   = 8'd0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
    logic [8:0]           cfg_data  = 9'd0;
    logic                 edge_strobe;
    logic [17:0]          edge_index;
    logic signed [1:0]    edge_value;
    logic                 last_edge;

    int errors;
    int outstanding;
    int cycle_cnt = 0;
    int cur_w     = 256;
    int cur_h     = 256;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    selection_outline_edge_update u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .edge_strobe (edge_strobe),
        .edge_index  (edge_index),
        .edge_value  (edge_value),
        .last_edge   (last_edge)
    );

    selection_outline_edge_update_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .edge_strobe (edge_strobe),
        .edge_index  (edge_index),
        .edge_value  (edge_value),
        .last_edge   (last_edge),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("selection_outline_edge_update regression: fail");
            $finish;
        end
    end

    // called at a falling edge; leaves start high so a burst can continue
    task automatic send_item(input logic f, input int x, input int y);
        start   <= 1'b1;
        func    <= f;
        pixel_x <= 8'(x);
        pixel_y <= 8'(y);
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic idle(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int raw);
        int v;
        start <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        // items with no updates may still be in flight
        repeat (6) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 9'(raw);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        v = raw & 'h1FF;
        v = (v == 0) ? 1 : ((v > 256) ? 256 : v);
        if (idx == REG_GRID_WIDTH)
        begin
            cur_w = v;
        end
        else if (idx == REG_GRID_HEIGHT)
        begin
            cur_h = v;
        end
    endtask

    // mostly clustered pixels so neighbors get exercised
    task automatic run_random(input int count);
        int sent;
        int blen;
        int win_w;
        int win_h;
        int wx;
        int wy;
        int sel;
        int x;
        int y;
        logic f;
        sent = 0;
        while (sent < count)
        begin
            blen  = $urandom_range(1, 8);
            win_w = (cur_w < 6) ? cur_w : 6;
            win_h = (cur_h < 6) ? cur_h : 6;
            wx    = $urandom_range(0, cur_w - win_w);
            wy    = $urandom_range(0, cur_h - win_h);
            for (int k = 0; k < blen && sent < count; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 85)
                begin
                    x = wx + $urandom_range(0, win_w - 1);
                    y = wy + $urandom_range(0, win_h - 1);
                end
                else if (sel < 95)
                begin
                    x = $urandom_range(0, cur_w - 1);
                    y = $urandom_range(0, cur_h - 1);
                end
                else
                begin
                    x = $urandom_range(0, 255);
                    y = $urandom_range(0, 255);
                end
                f = ($urandom_range(0, 99) < 60) ? FUNC_ADD : FUNC_REMOVE;
                send_item(f, x, y);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                idle($urandom_range(1, 6));
            end
        end
        idle(1);
    endtask

    initial
    begin
        int set_w [9];
        int set_h [9];
        int wait_cnt;
        set_w = '{256, 1, 3, 16, 511, 1, 9, 300, 0};
        set_h = '{256, 1, 2, 8, 1, 0, 17, 256, 0};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default 256x256 grid: corners, neighbors, no-change requests
        send_item(FUNC_ADD, 0, 0);
        send_item(FUNC_ADD, 255, 255);
        send_item(FUNC_ADD, 1, 0);
        send_item(FUNC_ADD, 0, 1);
        send_item(FUNC_ADD, 0, 0);
        send_item(FUNC_REMOVE, 5, 5);
        send_item(FUNC_ADD, 1, 1);
        send_item(FUNC_ADD, 2, 1);
        send_item(FUNC_ADD, 1, 2);
        send_item(FUNC_REMOVE, 1, 1);
        send_item(FUNC_REMOVE, 0, 0);
        send_item(FUNC_REMOVE, 255, 255);
        send_item(FUNC_ADD, 255, 0);
        idle(1);

        // unknown register: map must survive
        write_reg(REG_SPARE_2, 5);
        send_item(FUNC_REMOVE, 255, 0);
        idle(1);

        // zero width clamps to one column
        write_reg(REG_GRID_WIDTH, 0);
        write_reg(REG_GRID_HEIGHT, 3);
        send_item(FUNC_ADD, 1, 0);
        send_item(FUNC_ADD, 0, 3);
        send_item(FUNC_ADD, 0, 1);
        send_item(FUNC_ADD, 0, 0);
        send_item(FUNC_ADD, 0, 2);
        send_item(FUNC_REMOVE, 0, 1);
        idle(1);

        // oversize values clamp to the maximum
        write_reg(REG_GRID_WIDTH, 511);
        write_reg(REG_GRID_HEIGHT, 511);
        send_item(FUNC_ADD, 128, 200);
        send_item(FUNC_ADD, 255, 254);
        idle(1);

        for (int p = 0; p < 9; p++)
        begin
            if (p == 8)
            begin
                set_w[p] = $urandom_range(1, 256);
                set_h[p] = $urandom_range(1, 256);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_GRID_WIDTH, set_w[p]);
                write_reg(REG_GRID_HEIGHT, set_h[p]);
            end
            else
            begin
                write_reg(REG_GRID_HEIGHT, set_h[p]);
                write_reg(REG_GRID_WIDTH, set_w[p]);
            end
            if (p == 3 || p == 6)
            begin
                write_reg((p == 3) ? REG_SPARE_3 : REG_SPARE_2, $urandom_range(0, 511));
            end
            run_random(ITEMS_PER_SET);
        end

        start <= 1'b0;
        wait_cnt = 0;
        while (outstanding != 0 && wait_cnt < 1000)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (10) @(negedge clk);
        if (errors == 0 && outstanding == 0)
        begin
            $display("selection_outline_edge_update regression: pass");
        end
        else
        begin
            $display("selection_outline_edge_update regression: fail");
        end
        $finish;
    end

endmodule
